// ----- design/open_addressing_hash_table_top_macros.svh -----
// Assertion macros used by the checker file of the hash table.
`ifndef OPEN_ADDRESSING_HASH_TABLE_TOP_MACROS_SVH
`define OPEN_ADDRESSING_HASH_TABLE_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define OAHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define OAHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/oaht_pkg.sv -----
// Shared constants and codes of the open-addressing hash table.
package oaht_pkg;

    localparam int unsigned OAHT_DEPTH = 1024;

    localparam int unsigned KEY_W   = 32;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned ST_W    = 3;
    localparam int unsigned FLD_W   = 10;
    localparam int unsigned IN_W    = 40;
    localparam int unsigned OUT_W   = 40;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned CDATA_W = 32;
    localparam int unsigned TSIZE_W = 11;
    localparam int unsigned LG_W    = 4;

    localparam logic [CMD_W-1:0] CMD_MEMBER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

    localparam logic [ST_W-1:0] ST_FOUND    = 3'd0;
    localparam logic [ST_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [ST_W-1:0] ST_DELETED  = 3'd2;
    localparam logic [ST_W-1:0] ST_ABSENT   = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

    localparam logic [CIDX_W-1:0] CFG_PROBE = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_HASH  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_SIZE  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_LOG   = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_MULT  = 3'd4;

    localparam logic [TSIZE_W-1:0] SIZE_RESET = 11'd1024;
    localparam logic [LG_W-1:0]    LOG_RESET  = 4'd10;
    localparam logic [KEY_W-1:0]   MULT_RESET = 32'd2654435769;

endpackage

// ----- design/open_addressing_hash_table_top.sv -----
// Top level of the open-addressing hash table with linear or double-hash probing.
//
// An item on the slave stream carries a command (member, insert, delete or no-op) and a key.
// Each item gives exactly one result on the master stream: status, home slot,
// probe distance and the slot that decided the outcome.
// The configuration channel writes probing rule, hash type, size, log size and
// multiplier; it is always ready and should only be used while the block is idle.
// After acceptance an item forms its home slot and step in a multiply step, a set-up
// step and 32 steps of two parallel remainder units, then reads and evaluates each
// probed slot through the single-port slot memory, clears the last vacated slot of a
// delete, and loads the result.
// After reset the block sweeps the slot memory, one entry a cycle, before it accepts
// its first item.
// The result waits in an output register; the next item is accepted meanwhile,
// and a finished result is held back until the receiver takes the previous one.
module open_addressing_hash_table_top #(
    parameter int unsigned TABLE_DEPTH = oaht_pkg::OAHT_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // command [1:0], key [33:2], zero [39:34]
    input  logic [oaht_pkg::IN_W-1:0]    i_s_axis_tdata,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // status [2:0], home_bucket [12:3], distance [22:13], slot [32:23], zero [39:33]
    output logic [oaht_pkg::OUT_W-1:0]   o_m_axis_tdata,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [oaht_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [oaht_pkg::CDATA_W-1:0] i_cfg_data
);
    import oaht_pkg::*;

    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned MW = IW + 1;
    localparam int unsigned BW = $clog2(KEY_W);

    typedef enum logic [8:0] {
        S_CLR  = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_MUL  = 9'b000000100,
        S_PREP = 9'b000001000,
        S_DIV  = 9'b000010000,
        S_RD   = 9'b000100000,
        S_EV   = 9'b001000000,
        S_FIN  = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    t_state r_state;

    logic               r_policy, r_htype;
    logic [TSIZE_W-1:0] r_tsize;
    logic [LG_W-1:0]    r_lg;
    logic [KEY_W-1:0]   r_mult;

    logic [CMD_W-1:0] r_cmd;
    logic [KEY_W-1:0] r_key, r_prod, r_da, r_db;
    logic [MW-1:0]    r_m, r_divb;
    logic [IW-1:0]    r_rema, r_remb, r_home, r_step, r_idx, r_prev, r_dist;
    logic [IW-1:0]    r_rem_slot, r_rem_dist, r_clr;
    logic [BW-1:0]    r_bit;
    logic             r_removed;
    logic [KEY_W:0]   r_rdata;
    logic [ST_W-1:0]  r_st;
    logic [IW-1:0]    r_res_dist, r_res_slot;
    logic             r_ovalid;
    logic [OUT_W-1:0] r_odata;

    logic [KEY_W:0] r_mem [TABLE_DEPTH];

    logic [MW-1:0]    n_m;
    logic [MW-1:0]    sha, shb, sum;
    logic [IW-1:0]    rema_nx, remb_nx, nxt, del_slot, del_dist;
    logic [KEY_W-1:0] prod_a, prod_b;
    logic             ev_valid, hit, wrap, is_del, removed_nx;
    logic             w_en;
    logic [IW-1:0]    w_addr;
    logic [KEY_W:0]   w_data;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    always_comb begin
        if ({5'd0, r_tsize} < 16'd3) begin
            n_m = MW'(3);
        end else if (32'(r_tsize) > TABLE_DEPTH) begin
            n_m = MW'(TABLE_DEPTH);
        end else begin
            n_m = MW'(r_tsize);
        end
    end

    assign prod_a  = KEY_W'({32'd0, r_prod} >> (6'd32 - {2'd0, r_lg}));
    assign prod_b  = KEY_W'({32'd0, r_prod} >> (6'd32 - {1'b0, r_lg, 1'b0}));
    assign sha     = {r_rema, r_da[KEY_W-1]};
    assign shb     = {r_remb, r_db[KEY_W-1]};
    assign rema_nx = (sha >= r_m) ? IW'(sha - r_m) : IW'(sha);
    assign remb_nx = (shb >= r_divb) ? IW'(shb - r_divb) : IW'(shb);

    assign ev_valid   = r_rdata[KEY_W];
    assign hit        = (r_rdata[KEY_W-1:0] == r_key);
    assign is_del     = (r_cmd == CMD_DELETE);
    assign removed_nx = is_del && (r_removed || hit);
    assign sum        = {1'b0, r_idx} + {1'b0, r_step};
    assign nxt        = (sum >= r_m) ? IW'(sum - r_m) : IW'(sum);
    assign wrap       = (nxt == r_home);
    assign del_slot   = r_removed ? r_rem_slot : r_idx;
    assign del_dist   = r_removed ? r_rem_dist : r_dist;

    always_comb begin
        w_en   = 1'b0;
        w_addr = r_prev;
        w_data = '0;
        case (r_state)
            S_CLR: begin
                w_en   = 1'b1;
                w_addr = r_clr;
            end
            S_EV: begin
                if (!ev_valid && r_cmd == CMD_INSERT) begin
                    w_en   = 1'b1;
                    w_addr = r_idx;
                    w_data = {1'b1, r_key};
                end else if (ev_valid && is_del && r_removed) begin
                    w_en   = 1'b1;
                    w_data = {1'b1, r_rdata[KEY_W-1:0]};
                end
            end
            S_FIN: begin
                w_en = 1'b1;
            end
            default: begin
                w_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        if (r_state == S_RD) begin
            r_rdata <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= 1'b0;
            r_htype  <= 1'b0;
            r_tsize  <= SIZE_RESET;
            r_lg     <= LOG_RESET;
            r_mult   <= MULT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PROBE: r_policy <= i_cfg_data[0];
                CFG_HASH:  r_htype  <= i_cfg_data[0];
                CFG_SIZE:  r_tsize  <= i_cfg_data[TSIZE_W-1:0];
                CFG_LOG:   r_lg     <= i_cfg_data[LG_W-1:0];
                CFG_MULT:  r_mult   <= i_cfg_data;
                default:   r_policy <= r_policy;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_m_axis_tready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == IW'(TABLE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_cmd   <= i_s_axis_tdata[CMD_W-1:0];
                        r_key   <= i_s_axis_tdata[CMD_W +: KEY_W];
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= KEY_W'(r_key * r_mult);
                    r_m     <= n_m;
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_da   <= r_htype ? prod_a : r_key;
                    r_rema <= '0;
                    r_remb <= '0;
                    r_bit  <= BW'(KEY_W - 1);
                    if (!r_policy) begin
                        r_db   <= KEY_W'(1);
                        r_divb <= r_m;
                    end else if (!r_htype) begin
                        r_db   <= r_key;
                        r_divb <= r_m - MW'(2);
                    end else begin
                        r_db   <= prod_b | KEY_W'(1);
                        r_divb <= r_m;
                    end
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rema <= rema_nx;
                    r_remb <= remb_nx;
                    r_da   <= {r_da[KEY_W-2:0], 1'b0};
                    r_db   <= {r_db[KEY_W-2:0], 1'b0};
                    r_bit  <= r_bit - 1'b1;
                    if (r_bit == '0) begin
                        r_home    <= rema_nx;
                        r_idx     <= rema_nx;
                        r_step    <= (r_policy && !r_htype) ? remb_nx + 1'b1 : remb_nx;
                        r_dist    <= '0;
                        r_removed <= 1'b0;
                        if (r_cmd == CMD_NOP) begin
                            r_st       <= ST_ABSENT;
                            r_res_dist <= '0;
                            r_res_slot <= rema_nx;
                            r_state    <= S_DONE;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_EV;
                end
                S_EV: begin
                    if (!ev_valid) begin
                        if (r_cmd == CMD_INSERT) begin
                            r_st       <= ST_INSERTED;
                            r_res_dist <= r_dist;
                            r_res_slot <= r_idx;
                            r_state    <= S_DONE;
                        end else if (is_del && r_removed) begin
                            r_st       <= ST_DELETED;
                            r_res_dist <= r_rem_dist;
                            r_res_slot <= r_rem_slot;
                            r_state    <= S_FIN;
                        end else begin
                            r_st       <= ST_ABSENT;
                            r_res_dist <= r_dist;
                            r_res_slot <= r_idx;
                            r_state    <= S_DONE;
                        end
                    end else if (!is_del && hit) begin
                        r_st       <= ST_FOUND;
                        r_res_dist <= r_dist;
                        r_res_slot <= r_idx;
                        r_state    <= S_DONE;
                    end else begin
                        if (is_del && !r_removed && hit) begin
                            r_removed  <= 1'b1;
                            r_rem_slot <= r_idx;
                            r_rem_dist <= r_dist;
                            r_prev     <= r_idx;
                        end else if (is_del && r_removed) begin
                            r_prev <= r_idx;
                        end
                        if (wrap) begin
                            if (r_cmd == CMD_INSERT) begin
                                r_st       <= ST_FULL;
                                r_res_dist <= r_dist;
                                r_res_slot <= r_idx;
                                r_state    <= S_DONE;
                            end else if (removed_nx) begin
                                r_st       <= ST_DELETED;
                                r_res_dist <= del_dist;
                                r_res_slot <= del_slot;
                                r_state    <= S_FIN;
                            end else begin
                                r_st       <= ST_ABSENT;
                                r_res_dist <= r_dist;
                                r_res_slot <= r_idx;
                                r_state    <= S_DONE;
                            end
                        end else begin
                            r_idx   <= nxt;
                            r_dist  <= r_dist + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                S_FIN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {7'd0, FLD_W'(r_res_slot), FLD_W'(r_res_dist),
                                     FLD_W'(r_home), r_st};
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLR;
                end
            endcase
        end
    end

endmodule

// ----- design/oaht_check.sv -----
// Port-level checker of the hash table and its bind to the top level.
`include "open_addressing_hash_table_top_macros.svh"

module oaht_check (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_s_axis_tvalid,
    input logic                         o_s_axis_tready,
    input logic [oaht_pkg::IN_W-1:0]    i_s_axis_tdata,
    input logic                         o_m_axis_tvalid,
    input logic                         i_m_axis_tready,
    input logic [oaht_pkg::OUT_W-1:0]   o_m_axis_tdata,
    input logic                         i_cfg_valid,
    input logic                         o_cfg_ready,
    input logic [oaht_pkg::CIDX_W-1:0]  i_cfg_index,
    input logic [oaht_pkg::CDATA_W-1:0] i_cfg_data
);
    import oaht_pkg::*;

    `OAHT_ASSERT_NOW(a_status_code, o_m_axis_tvalid, o_m_axis_tdata[2:0] <= ST_FULL, "status code out of range")
    `OAHT_ASSERT_NOW(a_zero_dist_home, o_m_axis_tvalid && o_m_axis_tdata[22:13] == 10'd0, o_m_axis_tdata[32:23] == o_m_axis_tdata[12:3], "zero distance away from home slot")
    `OAHT_ASSERT_NEXT(a_busy_after_item, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "second item taken while busy")
    `OAHT_ASSERT_NEXT(a_result_held, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed")

endmodule

bind open_addressing_hash_table_top oaht_check u_oaht_check (.*);
